[hw/rtl/pmc_pkg.sv]
// ----------------------------------------------------------------------------
// pmc_pkg - point multiplicity counter package
// Sizes, token type and controller states shared by the cell chain and top.
// ----------------------------------------------------------------------------
package pmc_pkg;

	localparam int MAX_POINTS = 64;   // chain length, 2..64
	localparam int COORD_W    = 32;
	localparam int IDX_W      = 6;    // point_index width
	localparam int CNT_W      = 7;    // multiplicity / load count width

	// point travelling down the chain toward its own cell
	typedef struct packed {
		logic                      vld;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      miss;
		logic [IDX_W-1:0]          idx;   // destination cell
		logic [CNT_W-1:0]          cnt;   // matches seen so far
	} tok_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

[hw/rtl/pmc_if.sv]
// ----------------------------------------------------------------------------
// pmc_if - point and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pmc_pt_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic               is_missing;
	logic               last_point;

	modport source (output valid, x_coord, y_coord, is_missing, last_point, input ready);
	modport sink   (input valid, x_coord, y_coord, is_missing, last_point, output ready);
endinterface

interface pmc_res_if;
	logic       valid;
	logic       ready;
	logic [5:0] point_index;
	logic [6:0] multiplicity;
	logic       overflowed;
	logic       last_result;

	modport source (output valid, point_index, multiplicity, overflowed, last_result,
		input ready);
	modport sink   (input valid, point_index, multiplicity, overflowed, last_result,
		output ready);
endinterface

[hw/rtl/pmc_cell.sv]
// ----------------------------------------------------------------------------
// pmc_cell - one point slot of the chain
// Holds one point and its count; compares the passing token, stores it when
// the token reaches its own slot, shifts counts toward cell 0 on readout.
// ----------------------------------------------------------------------------
module pmc_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [pmc_pkg::IDX_W-1:0] idx,     // position of this cell
	input  pmc_pkg::tok_t           tok_up,  // token from previous cell
	output pmc_pkg::tok_t           tok_dn,  // token to next cell
	input  logic                    shift,   // readout advance
	input  logic [pmc_pkg::CNT_W-1:0] cnt_nb, // count of next cell
	output logic [pmc_pkg::CNT_W-1:0] cnt
);
	import pmc_pkg::*;

	logic signed [COORD_W-1:0] x_q, y_q;
	logic                      miss_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      here, hit;

	// outgoing token: valid bit under reset, payload free-running
	logic                      vld_q;
	logic signed [COORD_W-1:0] xd_q, yd_q;
	logic                      missd_q;
	logic [IDX_W-1:0]          idxd_q;
	logic [CNT_W-1:0]          cntd_q;

	// token destined for this slot, or an equal real point passing by
	assign here = tok_up.vld && (tok_up.idx == idx);
	assign hit  = tok_up.vld && !here && !tok_up.miss && !miss_q &&
		(tok_up.x == x_q) && (tok_up.y == y_q);

	always_ff @(posedge clk) begin
		if (here) begin
			x_q    <= tok_up.x;
			y_q    <= tok_up.y;
			miss_q <= tok_up.miss;
			cnt_q  <= tok_up.miss ? '0 : tok_up.cnt + CNT_W'(1);
		end else if (hit) begin
			cnt_q  <= cnt_q + CNT_W'(1);
		end else if (shift) begin
			cnt_q  <= cnt_nb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_up.vld && !here;
		end
	end

	always_ff @(posedge clk) begin
		xd_q    <= tok_up.x;
		yd_q    <= tok_up.y;
		missd_q <= tok_up.miss;
		idxd_q  <= tok_up.idx;
		cntd_q  <= tok_up.cnt + CNT_W'(hit);
	end

	assign tok_dn = '{vld: vld_q, x: xd_q, y: yd_q, miss: missd_q, idx: idxd_q,
		cnt: cntd_q};

	assign cnt = cnt_q;

endmodule

[hw/rtl/point_multiplicity_counter_top.sv]
// ----------------------------------------------------------------------------
// point_multiplicity_counter_top - duplicate point count over a point list
// Loads up to MAX_POINTS points into a chain of cells, then reports for each
// loaded point how many real stored points share its x and y (0 for a missing point).
// ----------------------------------------------------------------------------
//  channel | dir | transfer                     | payload
//  pts     | in  | one point of the list        | x_coord y_coord is_missing last_point
//  res     | out | one result per stored point  | point_index multiplicity overflowed
//          |     |                              | last_result
//
// While loading, each point enters cell 0 as a token and walks one cell per
// cycle until it reaches its own slot, comparing as it goes. After the last
// point the chain drains while drain_q counts down from n (n = points stored),
// then n results leave at one per cycle while res.ready is high, read from
// cell 0 as counts shift down. No point is taken while draining or reporting.
// Reset empties the list; cell contents are not cleared, only written slots
// are read. A stalled result holds the chain still.
// ----------------------------------------------------------------------------
module point_multiplicity_counter_top (
	input  logic       clk,
	input  logic       arst_n,
	pmc_pt_if.sink     pts,
	pmc_res_if.source  res
);
	import pmc_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   n_q;      // points stored in this list
	logic               ovf_q;    // a point was dropped
	logic [CNT_W-1:0]   drain_q;  // cycles left until the chain is settled
	logic [IDX_W-1:0]   oidx_q;   // result being reported

	logic               pt_xfer, res_xfer, room, res_last;
	logic [CNT_W-1:0]   n_nxt;

	tok_t               tok [MAX_POINTS+1];
	logic [CNT_W-1:0]   cnt [MAX_POINTS+1];
	logic [MAX_POINTS-1:0] tok_vld;

	assign pt_xfer  = pts.valid && pts.ready;
	assign res_xfer = res.valid && res.ready;
	assign room     = (n_q < CNT_W'(MAX_POINTS));
	assign n_nxt    = room ? n_q + CNT_W'(1) : n_q;
	assign res_last = ({1'b0, oidx_q} == n_q - CNT_W'(1));

	// ---------------- controller ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (pt_xfer && pts.last_point) state_d = ST_DRAIN;
			ST_DRAIN: if (drain_q == '0) state_d = ST_EMIT;
			ST_EMIT:  if (res_xfer && res_last) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		pts.ready = (state_q == ST_LOAD);
		res.valid = (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q     <= '0;
			ovf_q   <= 1'b0;
			drain_q <= '0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: if (pt_xfer) begin
					n_q <= n_nxt;
					if (!room) ovf_q <= 1'b1;
					if (pts.last_point) drain_q <= n_nxt;
				end
				ST_DRAIN: if (drain_q != '0) begin
					drain_q <= drain_q - CNT_W'(1);
				end
				ST_EMIT: if (res_xfer) begin
					if (res_last) begin
						n_q    <= '0;
						ovf_q  <= 1'b0;
						oidx_q <= '0;
					end else begin
						oidx_q <= oidx_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- token injection ----------------
	always_comb begin
		tok[0].vld  = pt_xfer && room;
		tok[0].x    = pts.x_coord;
		tok[0].y    = pts.y_coord;
		tok[0].miss = pts.is_missing;
		tok[0].idx  = n_q[IDX_W-1:0];
		tok[0].cnt  = '0;
	end

	assign cnt[MAX_POINTS] = '0;

	// ---------------- cell chain ----------------
	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		pmc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(k)),
			.tok_up (tok[k]),
			.tok_dn (tok[k+1]),
			.shift  (res_xfer),
			.cnt_nb (cnt[k+1]),
			.cnt    (cnt[k])
		);
		assign tok_vld[k] = tok[k+1].vld;
	end

	// ---------------- result ----------------
	assign res.point_index  = oidx_q;
	assign res.multiplicity = cnt[0];
	assign res.overflowed   = ovf_q;
	assign res.last_result  = res_last;

	// ---------------- checks ----------------
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		pts.ready |-> !res.valid)
		else $error("point accepted while results pending");

	a_settled: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (tok_vld == '0))
		else $error("token still in chain during readout");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ({1'b0, oidx_q} < n_q))
		else $error("result index beyond stored points");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_xfer && res.last_result) |=> (pts.ready && n_q == '0 && !ovf_q))
		else $error("list not emptied after last result");

endmodule

[dv/pmc_checker.sv]
// ----------------------------------------------------------------------------
// pmc_checker - duplicate point count scoreboard
// Watches both channels, mirrors the point list and predicts per-point counts.
// ----------------------------------------------------------------------------
module pmc_checker (
	input  logic clk,
	input  logic arst_n,
	pmc_pt_if    pts,
	pmc_res_if   res,
	output int   fail_count,
	output int   exp_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [5:0] point_index;
		logic [6:0] multiplicity;
		logic       overflowed;
		logic       last_result;
	} count_rec_t;

	logic signed [31:0] list_x    [pmc_pkg::MAX_POINTS];
	logic signed [31:0] list_y    [pmc_pkg::MAX_POINTS];
	bit                 list_miss [pmc_pkg::MAX_POINTS];
	int                 list_len     = 0;
	bit                 list_dropped = 1'b0;
	count_rec_t         counts_due[$];
	int                 fails = 0;

	// count equal real points for every stored point, queue in load order
	task automatic tally_duplicates();
		int         hits;
		count_rec_t rec;
		for (int i = 0; i < list_len; i++) begin
			hits = 0;
			if (!list_miss[i]) begin
				for (int j = 0; j < list_len; j++) begin
					if (!list_miss[j] && list_x[j] === list_x[i] && list_y[j] === list_y[i])
						hits++;
				end
			end
			rec.point_index  = 6'(i);
			rec.multiplicity = 7'(hits);
			rec.overflowed   = list_dropped;
			rec.last_result  = (i == list_len - 1);
			counts_due.push_back(rec);
		end
		list_len     = 0;
		list_dropped = 1'b0;
	endtask

	task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		count_rec_t want;
		if (!arst_n) begin
			list_len     = 0;
			list_dropped = 1'b0;
			counts_due.delete();
		end else begin
			if (pts.valid && pts.ready) begin
				if (list_len < pmc_pkg::MAX_POINTS) begin
					list_x[list_len]    = pts.x_coord;
					list_y[list_len]    = pts.y_coord;
					list_miss[list_len] = pts.is_missing;
					list_len++;
				end else begin
					list_dropped = 1'b1;
				end
				if (pts.last_point)
					tally_duplicates();
			end
			if (res.valid && res.ready) begin
				if (counts_due.size() == 0) begin
					$display("%0t: result transfer with none expected, got index %0d count %0d",
						$time, res.point_index, res.multiplicity);
					fails++;
				end else begin
					want = counts_due.pop_front();
					check_field("point_index", 7'(want.point_index), 7'(res.point_index));
					check_field("multiplicity", want.multiplicity, res.multiplicity);
					check_field("overflowed", 7'(want.overflowed), 7'(res.overflowed));
					check_field("last_result", 7'(want.last_result), 7'(res.last_result));
				end
			end
		end
		fail_count  <= fails;
		exp_pending <= counts_due.size();
	end

endmodule

[dv/point_multiplicity_counter_top_tb.sv]
// ----------------------------------------------------------------------------
// point_multiplicity_counter_top_tb - duplicate point count testbench
// Feeds directed and random point lists with random gaps and result stalls,
// including one long result hold-off; a checker module scores every result.
// ----------------------------------------------------------------------------
module point_multiplicity_counter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int ITEM_TARGET  = 420;
	localparam int HOLD_CYCLES  = 500;     // long result hold-off
	localparam int HOLD_AT_ITEM = 40;
	// random lists with a fixed shape
	localparam int FULL_LIST_NO  = 2;      // exactly full, all the same point
	localparam int OVER3_LIST_NO = 5;      // three points past capacity
	localparam int OVER1_LIST_NO = 8;      // one point past capacity

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		bit                 miss;
	} map_point_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       hold_off;
	int         fail_count;
	int         exp_pending;
	int         points_sent = 0;
	int         cycle_count = 0;
	map_point_t plist[$];

	pmc_pt_if  pts_if();
	pmc_res_if res_if();

	always #5 clk = ~clk;

	point_multiplicity_counter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts_if),
		.res    (res_if)
	);

	pmc_checker count_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.pts         (pts_if),
		.res         (res_if),
		.fail_count  (fail_count),
		.exp_pending (exp_pending)
	);

	// ------------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------------
	function automatic map_point_t mk_point(logic signed [31:0] x, logic signed [31:0] y,
		bit miss);
		map_point_t p;
		p.x    = x;
		p.y    = y;
		p.miss = miss;
		return p;
	endfunction

	// full 32-bit random, minus the one pattern outside the legal range
	function automatic logic signed [31:0] any_coord();
		logic [31:0] v;
		v = $urandom;
		if (v == 32'h8000_0000)
			v = 32'h8000_0001;
		return v;
	endfunction

	// one point transfer; gap = idle cycles with valid low before offering
	task automatic send_point(map_point_t p, bit last, int gap);
		if (gap > 0) begin
			pts_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pts_if.valid      <= 1'b1;
		pts_if.x_coord    <= p.x;
		pts_if.y_coord    <= p.y;
		pts_if.is_missing <= p.miss;
		pts_if.last_point <= last;
		@(posedge clk);
		while (!pts_if.ready) @(posedge clk);
		points_sent++;
	endtask

	// send the queued list, last flag on its final point
	task automatic send_list(bit burst);
		for (int i = 0; i < plist.size(); i++)
			send_point(plist[i], i == plist.size() - 1, burst ? 0 : $urandom_range(0, 8));
		plist.delete();
	endtask

	// coordinates come mostly from small per-list pools so duplicates are
	// common; x and y pools are independent, which also gives near misses
	// (same x, other y and the reverse)
	task automatic build_random_list(int len, bit same_point);
		logic signed [31:0] xs [4];
		logic signed [31:0] ys [4];
		map_point_t         p;
		int                 pool_n;
		pool_n = $urandom_range(1, 4);
		for (int k = 0; k < 4; k++) begin
			xs[k] = any_coord();
			ys[k] = any_coord();
		end
		for (int i = 0; i < len; i++) begin
			if (same_point) begin
				p = mk_point(xs[0], ys[0], 1'b0);
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					p.x = any_coord();
					p.y = any_coord();
				end else begin
					p.x = xs[$urandom_range(0, pool_n - 1)];
					p.y = ys[$urandom_range(0, pool_n - 1)];
				end
				p.miss = ($urandom_range(0, 5) == 0);
			end
			plist.push_back(p);
		end
	endtask

	// ------------------------------------------------------------------------
	// result side: random stall per transfer, runs of zero stall, and the
	// long hold-off while hold_off is up
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		int run_left;
		bit steady;
		res_if.ready <= 1'b0;
		run_left = 0;
		steady   = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (run_left == 0) begin
				steady   = ($urandom_range(0, 3) == 0);
				run_left = $urandom_range(1, 20);
			end
			run_left--;
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0 || hold_off) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
		end
	end

	// hold results off for a long stretch while points keep coming; the
	// block parks in its report phase and must stop taking points
	initial begin : backpressure
		hold_off <= 1'b0;
		wait (points_sent >= HOLD_AT_ITEM);
		@(posedge clk);
		hold_off <= 1'b1;
		for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
		hold_off <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("point_multiplicity_counter_top: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and verdict
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int list_no;
		int len;
		arst_n            <= 1'b0;
		pts_if.valid      <= 1'b0;
		pts_if.x_coord    <= '0;
		pts_if.y_coord    <= '0;
		pts_if.is_missing <= 1'b0;
		pts_if.last_point <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single real point at the coordinate extremes: count 1, last at once
		plist.push_back(mk_point(2147483647, -2147483647, 1'b0));
		send_list(1'b0);
		// single missing point: count 0
		plist.push_back(mk_point(0, 0, 1'b1));
		send_list(1'b0);
		// mixed list: repeats, a missing point sharing coords with real ones,
		// same x other y, same y other x, all-ones and all-zeros patterns
		plist.push_back(mk_point(0, 0, 1'b0));
		plist.push_back(mk_point(-1, -1, 1'b0));
		plist.push_back(mk_point(0, 0, 1'b1));
		plist.push_back(mk_point(0, 0, 1'b0));
		plist.push_back(mk_point(-2147483647, 2147483647, 1'b0));
		plist.push_back(mk_point(-1, -1, 1'b0));
		plist.push_back(mk_point(0, 1, 1'b0));
		plist.push_back(mk_point(1, 0, 1'b0));
		plist.push_back(mk_point(2147483647, -2147483647, 1'b0));
		plist.push_back(mk_point(5, 5, 1'b0));
		send_list(1'b1);
		// all missing
		plist.push_back(mk_point(7, 7, 1'b1));
		plist.push_back(mk_point(7, 7, 1'b1));
		plist.push_back(mk_point(-1, -1, 1'b1));
		send_list(1'b0);
		// one point repeated, one copy flagged missing
		plist.push_back(mk_point(2147483647, 2147483647, 1'b0));
		plist.push_back(mk_point(2147483647, 2147483647, 1'b0));
		plist.push_back(mk_point(2147483647, 2147483647, 1'b1));
		plist.push_back(mk_point(2147483647, 2147483647, 1'b0));
		plist.push_back(mk_point(2147483647, 2147483647, 1'b0));
		send_list(1'b0);

		// random lists: mostly short, a few long, full and overflowing ones
		list_no = 0;
		while (points_sent < ITEM_TARGET) begin
			case (list_no)
				FULL_LIST_NO:  build_random_list(pmc_pkg::MAX_POINTS, 1'b1);
				OVER3_LIST_NO: build_random_list(pmc_pkg::MAX_POINTS + 3, 1'b0);
				OVER1_LIST_NO: build_random_list(pmc_pkg::MAX_POINTS + 1, 1'b0);
				default: begin
					len = ($urandom_range(0, 9) == 0) ?
						$urandom_range(20, pmc_pkg::MAX_POINTS) : $urandom_range(1, 10);
					build_random_list(len, 1'b0);
				end
			endcase
			send_list($urandom_range(0, 3) == 0);
			list_no++;
		end
		pts_if.valid <= 1'b0;

		// let the checker see the final transfer, then drain and linger
		@(posedge clk);
		while (exp_pending != 0) @(posedge clk);
		repeat (4 * pmc_pkg::MAX_POINTS) @(posedge clk);

		if (fail_count == 0)
			$display("point_multiplicity_counter_top: match");
		else
			$display("point_multiplicity_counter_top: mismatch");
		$finish;
	end

endmodule
